### rtl/core/wmsum_pkg.sv
// Shared types and constants for the window minimum sum unit.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package wmsum_pkg;

	localparam int MaxSize   = 256;
	localparam int SizeBits  = 9;
	localparam int IdxBits   = 8;
	localparam int AddrBits  = 2 * IdxBits;
	localparam int ValueBits = 32;
	localparam int SumBits   = 30;
	localparam int StepBits  = 5;

	localparam logic [SumBits-1:0]   SumModulus = 30'd1000000007;
	localparam logic [SizeBits-1:0]  SizeMax    = 9'(MaxSize);
	localparam logic [SizeBits-1:0]  SizeMin    = 9'd1;
	localparam logic [StepBits-1:0]  StepLast   = 5'(ValueBits - 1);

	// configuration register indexes
	localparam logic CfgMatrixSize = 1'b0;
	localparam logic CfgWindowSize = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FIRST, ST_MODX, ST_MODB, ST_MULD, ST_MULA, ST_ADDB,
		ST_CINIT, ST_CRD, ST_CCMP, ST_CWR, ST_WINIT, ST_WRD, ST_WCMP,
		ST_RED, ST_ACC, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_WR0, OP_MODX, OP_MODB, OP_MULD, OP_MULA, OP_ADDB,
		OP_CINIT, OP_CCMP, OP_CWR, OP_WINIT, OP_WCMP, OP_RED, OP_ACC, OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic n_one;
		logic step_last;
		logic col_last;
		logic r_last;
		logic do_min;
		logic v_ge_p;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

### rtl/core/wmsum_ctrl.sv
// Sequencing state machine for the window minimum sum unit.
// Depends on wmsum_pkg; drives commands to wmsum_dpath.
`default_nettype none

module wmsum_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire wmsum_pkg::status_t sts,
	output wmsum_pkg::cmd_t         cmd
);
	import wmsum_pkg::*;

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op   = OP_LOAD;
					state_nx = ST_FIRST;
				end
			end
			ST_FIRST: begin
				cmd.op = OP_WR0;
				if (sts.n_one) begin
					state_nx = sts.do_min ? ST_CINIT : ST_OUT;
				end else if (sts.m_zero) begin
					state_nx = ST_ADDB;
				end else begin
					state_nx = ST_MODX;
				end
			end
			ST_MODX: begin
				cmd.op = OP_MODX;
				if (sts.step_last) state_nx = ST_MODB;
			end
			ST_MODB: begin
				cmd.op = OP_MODB;
				if (sts.step_last) state_nx = ST_MULD;
			end
			ST_MULD: begin
				cmd.op   = OP_MULD;
				state_nx = ST_MULA;
			end
			ST_MULA: begin
				cmd.op   = OP_MULA;
				state_nx = sts.step_last ? ST_ADDB : ST_MULD;
			end
			ST_ADDB: begin
				cmd.op = OP_ADDB;
				if (sts.col_last) begin
					state_nx = sts.do_min ? ST_CINIT : ST_OUT;
				end else begin
					state_nx = sts.m_zero ? ST_ADDB : ST_MULD;
				end
			end
			ST_CINIT: begin
				cmd.op   = OP_CINIT;
				state_nx = ST_CRD;
			end
			ST_CRD: begin
				state_nx = ST_CCMP;
			end
			ST_CCMP: begin
				cmd.op   = OP_CCMP;
				state_nx = sts.r_last ? ST_CWR : ST_CRD;
			end
			ST_CWR: begin
				cmd.op   = OP_CWR;
				state_nx = sts.col_last ? ST_WINIT : ST_CRD;
			end
			ST_WINIT: begin
				cmd.op   = OP_WINIT;
				state_nx = ST_WRD;
			end
			ST_WRD: begin
				state_nx = ST_WCMP;
			end
			ST_WCMP: begin
				cmd.op   = OP_WCMP;
				state_nx = sts.r_last ? ST_RED : ST_WRD;
			end
			ST_RED: begin
				if (sts.v_ge_p) begin
					cmd.op = OP_RED;
				end else begin
					state_nx = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.op   = OP_ACC;
				state_nx = sts.col_last ? ST_OUT : ST_WRD;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.op   = OP_OUT;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/wmsum_dpath.sv
// Datapath for the window minimum sum unit: row generator, row store,
// column minima store, sum and output register. Depends on wmsum_pkg.
`default_nettype none

module wmsum_dpath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire wmsum_pkg::cmd_t                    cmd,
	input  wire logic [wmsum_pkg::SizeBits-1:0]     n,
	input  wire logic [wmsum_pkg::SizeBits-1:0]     k,
	input  wire logic [wmsum_pkg::ValueBits-1:0]    first_value,
	input  wire logic [wmsum_pkg::ValueBits-1:0]    multiplier,
	input  wire logic [wmsum_pkg::ValueBits-1:0]    increment,
	input  wire logic [wmsum_pkg::ValueBits-1:0]    modulus,
	input  wire logic                               out_stall,
	output wmsum_pkg::status_t                      sts,
	output logic                                    out_valid,
	output logic [wmsum_pkg::SumBits-1:0]           running_sum,
	output logic                                    matrix_done
);
	import wmsum_pkg::*;

	logic [ValueBits-1:0] first_q, a_q, b_q, m_q, xr_q, bm_q, rem_q, acc_q, mn_q;
	logic [StepBits-1:0]  step_q;
	logic [SizeBits-1:0]  col_q, r_q, rowcnt_q, row_no;
	logic [SumBits-1:0]   sum_q;
	logic                 out_valid_q;

	logic [ValueBits-1:0] row_mem [MaxSize*MaxSize];
	logic [ValueBits-1:0] cm_mem  [MaxSize];
	logic [ValueBits-1:0] row_rd_q, cm_rd_q;

	logic [IdxBits-1:0]   slot;
	logic [ValueBits-1:0] dvd, rem_nx, dbl_nx, add_nx, x_new, rd_sel, mn_nx;
	logic [ValueBits:0]   rem_sh, dbl, add, sb;
	logic [SumBits:0]     acc_sum;
	logic                 row_we;
	logic [AddrBits-1:0]  row_wa, row_ra;
	logic [ValueBits-1:0] row_wd;

	assign row_no = rowcnt_q + 9'd1;
	assign slot   = rowcnt_q[IdxBits-1:0];

	// one restoring division step for the remainder
	always_comb begin
		dvd    = (cmd.op == OP_MODB) ? b_q : first_q;
		rem_sh = {rem_q, dvd[StepLast - step_q]};
		rem_nx = (rem_sh >= {1'b0, m_q}) ? ValueBits'(rem_sh - {1'b0, m_q})
		                                 : rem_sh[ValueBits-1:0];
	end

	// double-and-add modular multiply, one half step per cycle
	always_comb begin
		dbl    = {acc_q, 1'b0};
		dbl_nx = (dbl >= {1'b0, m_q}) ? ValueBits'(dbl - {1'b0, m_q}) : dbl[ValueBits-1:0];
		add    = {1'b0, acc_q} + {1'b0, xr_q};
		add_nx = (add >= {1'b0, m_q}) ? ValueBits'(add - {1'b0, m_q}) : add[ValueBits-1:0];
		sb     = {1'b0, acc_q} + {1'b0, bm_q};
		if (m_q == '0) begin
			x_new = '0;
		end else begin
			x_new = (sb >= {1'b0, m_q}) ? ValueBits'(sb - {1'b0, m_q}) : sb[ValueBits-1:0];
		end
	end

	// minimum compare and sum accumulate
	always_comb begin
		rd_sel  = (cmd.op == OP_WCMP) ? cm_rd_q : row_rd_q;
		mn_nx   = (rd_sel < mn_q) ? rd_sel : mn_q;
		acc_sum = {1'b0, sum_q} + {1'b0, mn_q[SumBits-1:0]};
	end

	// row store: write port and registered read port
	always_comb begin
		row_we = (cmd.op == OP_WR0) || (cmd.op == OP_ADDB);
		row_wa = {slot, (cmd.op == OP_WR0) ? {IdxBits{1'b0}} : col_q[IdxBits-1:0]};
		row_wd = (cmd.op == OP_WR0) ? first_q : x_new;
		row_ra = {IdxBits'(slot - r_q[IdxBits-1:0]), col_q[IdxBits-1:0]};
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[row_wa] <= row_wd;
		row_rd_q <= row_mem[row_ra];
	end

	// column minima store
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CWR) cm_mem[col_q[IdxBits-1:0]] <= mn_q;
		cm_rd_q <= cm_mem[IdxBits'(col_q - r_q)];
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				first_q <= first_value;
				a_q     <= multiplier;
				b_q     <= increment;
				m_q     <= modulus;
				col_q   <= '0;
			end
			OP_WR0: begin
				col_q  <= 9'd1;
				rem_q  <= '0;
				step_q <= '0;
				acc_q  <= '0;
			end
			OP_MODX, OP_MODB: begin
				step_q <= step_q + 5'd1;
				if (step_q == StepLast) begin
					rem_q <= '0;
					if (cmd.op == OP_MODX) xr_q <= rem_nx;
					else bm_q <= rem_nx;
				end else begin
					rem_q <= rem_nx;
				end
			end
			OP_MULD: acc_q <= dbl_nx;
			OP_MULA: begin
				if (a_q[StepLast - step_q]) acc_q <= add_nx;
				step_q <= step_q + 5'd1;
			end
			OP_ADDB: begin
				xr_q   <= x_new;
				acc_q  <= '0;
				step_q <= '0;
				col_q  <= col_q + 9'd1;
			end
			OP_CINIT: begin
				col_q <= '0;
				r_q   <= '0;
				mn_q  <= '1;
			end
			OP_CCMP, OP_WCMP: begin
				mn_q <= mn_nx;
				r_q  <= r_q + 9'd1;
			end
			OP_CWR, OP_ACC: begin
				col_q <= col_q + 9'd1;
				r_q   <= '0;
				mn_q  <= '1;
			end
			OP_WINIT: begin
				col_q <= k - 9'd1;
				r_q   <= '0;
				mn_q  <= '1;
			end
			OP_RED: mn_q <= mn_q - {2'b00, SumModulus};
			default: ;
		endcase
	end

	// control state: sum, row count, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			rowcnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result takes the register in the cycle the old one leaves
			if (cmd.op == OP_OUT) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_ACC: begin
					sum_q <= (acc_sum >= {1'b0, SumModulus})
					         ? SumBits'(acc_sum - {1'b0, SumModulus})
					         : acc_sum[SumBits-1:0];
				end
				OP_OUT: begin
					if (row_no >= n) begin
						rowcnt_q <= '0;
						sum_q    <= '0;
					end else begin
						rowcnt_q <= row_no;
					end
				end
				default: ;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			running_sum <= sum_q;
			matrix_done <= (row_no >= n);
		end
	end

	assign out_valid = out_valid_q;

	// status to controller
	always_comb begin
		sts.m_zero    = (m_q == '0);
		sts.n_one     = (n == SizeMin);
		sts.step_last = (step_q == StepLast);
		sts.col_last  = (col_q == n - 9'd1);
		sts.r_last    = (r_q == k - 9'd1);
		sts.do_min    = (k <= n) && (row_no >= k);
		sts.v_ge_p    = (mn_q >= {2'b00, SumModulus});
		sts.out_free  = !out_valid_q || !out_stall;
	end

endmodule

`default_nettype wire

### rtl/core/window_min_sum_2d_unit.sv
// Top level of the window minimum sum unit: configuration registers,
// controller and datapath. Depends on wmsum_pkg, wmsum_ctrl, wmsum_dpath.
//
// Each request on the input channel (in_valid/in_stall) describes one matrix
// row by a generator: first_value, multiplier, increment, modulus. The block
// builds the N values of the row, keeps the last K rows, and from row K on
// adds the minimum of every K-by-K square ending in this row to a sum kept
// modulo 1000000007. Each row gives one result request: running_sum and
// matrix_done (set on row N, after which row count and sum clear). The
// generator reduces first_value and increment by the modulus, then makes
// each value by a double-and-add multiply and an add. Once K rows are held,
// column minima, then square minima are formed; all reads go through the
// single registered read port of each store. One row is worked on at a time;
// in_stall is high from acceptance until the result is loaded into the output
// register. A stalled result holds there while the next row is accepted.
// Configuration (cfg_valid/cfg_ready, always ready) is to be written by the
// user only while idle; the block does not enforce it. Reset sets N=256,
// K=1, clears the sum and row count; stored rows are undefined until written.
`default_nettype none

module window_min_sum_2d_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_index,
	input  wire logic [wmsum_pkg::SizeBits-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [wmsum_pkg::ValueBits-1:0]  first_value,
	input  wire logic [wmsum_pkg::ValueBits-1:0]  multiplier,
	input  wire logic [wmsum_pkg::ValueBits-1:0]  increment,
	input  wire logic [wmsum_pkg::ValueBits-1:0]  modulus,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [wmsum_pkg::SumBits-1:0]         running_sum,
	output logic                                  matrix_done
);
	import wmsum_pkg::*;

	logic [SizeBits-1:0] msize_q, wsize_q, n, k;
	status_t sts;
	cmd_t    cmd;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msize_q <= SizeMax;
			wsize_q <= SizeMin;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CfgMatrixSize: msize_q <= cfg_data;
				CfgWindowSize: wsize_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp sizes into 1..MaxSize
	always_comb begin
		n = (msize_q == '0) ? SizeMin : ((msize_q > SizeMax) ? SizeMax : msize_q);
		k = (wsize_q == '0) ? SizeMin : ((wsize_q > SizeMax) ? SizeMax : wsize_q);
	end

	wmsum_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	wmsum_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.n           (n),
		.k           (k),
		.first_value (first_value),
		.multiplier  (multiplier),
		.increment   (increment),
		.modulus     (modulus),
		.out_stall   (out_stall),
		.sts         (sts),
		.out_valid   (out_valid),
		.running_sum (running_sum),
		.matrix_done (matrix_done)
	);

`ifndef SYNTHESIS
	// a result never carries a sum outside the modulus
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (running_sum < SumModulus))
		else $error("running_sum out of range");

	// an accepted row blocks further requests until it is finished
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second request taken while a row is in work");

	// a new result is only loaded when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("pending result lost");
`endif

endmodule

`default_nettype wire

### tb/window_min_sum_2d_unit_test.sv
// Self-checking testbench for window_min_sum_2d_unit: directed table then random
// matrices, each row checked against a behavioural window-minimum-sum predictor or a typed result.
// Depends on wmsum_pkg and the window_min_sum_2d_unit RTL only.
`default_nettype none

module window_min_sum_2d_unit_test;
	import wmsum_pkg::*;

	localparam longint unsigned SumMod = 64'd1000000007;

	typedef enum logic [1:0] {DO_ROW, DO_CFG_N, DO_CFG_K} action_t;

	typedef struct {
		action_t     act;
		logic [31:0] fv, mult, inc, modv;
		logic [8:0]  size;
		bit          typed;
		logic [29:0] sum;
		logic        done;
	} step_t;

	typedef struct {
		logic [29:0] sum;
		logic        done;
	} row_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CfgMatrixSize;
	logic [SizeBits-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ValueBits-1:0] first_value = '0, multiplier = '0, increment = '0, modulus = 32'd1;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SumBits-1:0] running_sum;
	logic matrix_done;

	window_min_sum_2d_unit u_dut (.*);

	// predictor state
	logic [31:0] rows_seen [MaxSize][MaxSize];
	logic [31:0] col_min [MaxSize];
	logic [8:0]  n_reg = 9'd256, k_reg = 9'd1;
	longint unsigned sum_acc = 0;
	int unsigned row_count = 0;

	row_result_t sums_due[$];
	int errors = 0;
	int in_idle_pct = 0, out_stall_pct = 0;
	int hold_off = 0;

	// clock and reset
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned clamp9(logic [8:0] v);
		if (v == 0)
			return 1;
		if (v > MaxSize)
			return MaxSize;
		return v;
	endfunction

	// one row: build the generator row, then fold K-by-K square minima into the sum
	function automatic row_result_t predict_row(logic [31:0] fv, logic [31:0] mult,
			logic [31:0] inc, logic [31:0] modv);
		int unsigned n, k, slot, row_no, s;
		longint unsigned x;
		logic [31:0] mn;
		row_result_t res;
		n = clamp9(n_reg);
		k = clamp9(k_reg);
		slot = row_count % MaxSize;
		row_no = row_count + 1;
		x = fv;
		rows_seen[slot][0] = fv;
		for (int c = 1; c < n; c++) begin
			if (modv == 0)
				x = 0;
			else
				x = (((x % modv) * mult) % modv + inc) % modv;
			rows_seen[slot][c] = x[31:0];
		end
		if (k <= n && row_no >= k) begin
			for (int c = 0; c < n; c++) begin
				mn = '1;
				for (int r = 0; r < k; r++) begin
					s = (slot + MaxSize - r) % MaxSize;
					if (rows_seen[s][c] < mn)
						mn = rows_seen[s][c];
				end
				col_min[c] = mn;
			end
			for (int c = k - 1; c < n; c++) begin
				mn = '1;
				for (int r = 0; r < k; r++)
					if (col_min[c - r] < mn)
						mn = col_min[c - r];
				sum_acc = (sum_acc + longint'(mn) % SumMod) % SumMod;
			end
		end
		res.sum = sum_acc[29:0];
		res.done = (row_no >= n);
		if (res.done) begin
			row_count = 0;
			sum_acc = 0;
		end else
			row_count = row_no;
		return res;
	endfunction

	// offer one row request; predicted (or typed) result queued on acceptance
	task automatic send_row(logic [31:0] fv, logic [31:0] mult, logic [31:0] inc,
			logic [31:0] modv, bit typed, logic [29:0] sum, logic done);
		row_result_t res;
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		first_value = fv;
		multiplier = mult;
		increment = inc;
		modulus = modv;
		do
			@(posedge clk);
		while (in_stall);
		res = predict_row(fv, mult, inc, modv);
		if (typed) begin
			res.sum = sum;
			res.done = done;
		end
		sums_due.push_back(res);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// let all rows drain before touching configuration
	task automatic drain();
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [8:0] v);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CfgMatrixSize)
			n_reg = v;
		else
			k_reg = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver: random stall, or a counted hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_stall = 1'b1;
				hold_off--;
			end else
				out_stall = ($urandom_range(0, 99) < out_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		row_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected result sum=%0d done=%0b", $time, running_sum,
					matrix_done);
				errors++;
			end else begin
				exp_r = sums_due.pop_front();
				if (running_sum !== exp_r.sum) begin
					$display("%0t: running_sum expected %0d actual %0d", $time, exp_r.sum,
						running_sum);
					errors++;
				end
				if (matrix_done !== exp_r.done) begin
					$display("%0t: matrix_done expected %0b actual %0b", $time, exp_r.done,
						matrix_done);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] pick_mod();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return 32'd0;
			2, 3, 4: return $urandom_range(1, 50);
			default: return $urandom;
		endcase
	endfunction

	step_t plan [$];

	function automatic step_t row_step(logic [31:0] fv, logic [31:0] mult, logic [31:0] inc,
			logic [31:0] modv, bit typed = 0, logic [29:0] sum = 0, logic done = 0);
		step_t st;
		st = '{act: DO_ROW, fv: fv, mult: mult, inc: inc, modv: modv, size: 0,
			typed: typed, sum: sum, done: done};
		return st;
	endfunction

	function automatic step_t cfg_step(action_t act, logic [8:0] v);
		step_t st;
		st = '{act: act, fv: 0, mult: 0, inc: 0, modv: 1, size: v, typed: 0, sum: 0, done: 0};
		return st;
	endfunction

	initial begin
		int sent, rows_left;
		int unsigned n_pick, k_pick;
		// directed table: reset sizes, extremes, clamping, zero modulus, window past N
		plan.push_back(row_step(32'd1, 32'd3, 32'd7, 32'd1000));
		plan.push_back(row_step('1, '1, '1, '1));
		plan.push_back(cfg_step(DO_CFG_N, 9'd1));   // lowered mid-matrix: ends it
		plan.push_back(row_step('1, 32'd5, 32'd5, 32'd9));
		plan.push_back(row_step(32'd0, '1, '1, '1, 1, 30'd0, 1'b1));
		plan.push_back(row_step('1, 32'd0, 32'd0, 32'd1, 1, 30'd294967267, 1'b1));
		plan.push_back(cfg_step(DO_CFG_N, 9'd0));
		plan.push_back(row_step(32'd1000000007, '1, 32'd0, 32'd3, 1, 30'd0, 1'b1));
		plan.push_back(cfg_step(DO_CFG_N, 9'd511));
		plan.push_back(cfg_step(DO_CFG_K, 9'd256));
		plan.push_back(row_step(32'hA5A5_5A5A, 32'h1234_5678, 32'h0F0F_F0F0, 32'h7FFF_FFFF,
			1, 30'd0, 1'b0));
		plan.push_back(cfg_step(DO_CFG_N, 9'd2));   // window larger than matrix
		plan.push_back(row_step(32'd9, 32'd2, 32'd1, 32'd13, 1, 30'd0, 1'b1));
		plan.push_back(cfg_step(DO_CFG_N, 9'd3));
		plan.push_back(cfg_step(DO_CFG_K, 9'd0));
		plan.push_back(row_step(32'd5, 32'd7, 32'd1, 32'd0));
		plan.push_back(row_step(32'hFFFF_FFFF, 32'd7, 32'd1, 32'd0));
		plan.push_back(row_step(32'd4, 32'd3, 32'd2, 32'd11));
		plan.push_back(cfg_step(DO_CFG_K, 9'd3));
		plan.push_back(row_step(32'd80, 32'd6, 32'd5, 32'd97));
		plan.push_back(row_step(32'd40, 32'd0, 32'd1, 32'd1));
		plan.push_back(row_step(32'd60, 32'd2, 32'd9, 32'd101));
		plan.push_back(cfg_step(DO_CFG_N, 9'd4));
		plan.push_back(cfg_step(DO_CFG_K, 9'd2));
		for (int i = 0; i < 4; i++)
			plan.push_back(row_step($urandom, $urandom, $urandom, pick_mod()));

		@(posedge arst_n);
		@(negedge clk);
		foreach (plan[i]) begin
			case (plan[i].act)
				DO_CFG_N: write_cfg(CfgMatrixSize, plan[i].size);
				DO_CFG_K: write_cfg(CfgWindowSize, plan[i].size);
				default: send_row(plan[i].fv, plan[i].mult, plan[i].inc, plan[i].modv,
					plan[i].typed, plan[i].sum, plan[i].done);
			endcase
		end

		// random matrices under three idling regimes
		sent = 0;
		rows_left = 0;
		for (int phase = 0; phase < 3; phase++) begin
			in_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 61 : 0;
			out_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 21 : 0;
			while (sent < 28 * (phase + 1)) begin
				if (row_count == 0 && rows_left == 0) begin
					// new matrix: sizes only change on a matrix boundary
					n_pick = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 24)
						: $urandom_range(1, 12);
					k_pick = $urandom_range(1, n_pick + 1);
					write_cfg(CfgMatrixSize, n_pick[8:0]);
					write_cfg(CfgWindowSize, ($urandom_range(0, 29) == 0) ? 9'd400 : k_pick[8:0]);
					rows_left = n_pick;
				end
				if (phase == 2 && sent == 80)
					hold_off = 8000;  // output held off while rows keep coming
				if (sent == 50)
					drain();          // sender waits for every row to come back
				send_row($urandom, $urandom, $urandom, pick_mod(), 0, 0, 0);
				sent++;
				rows_left--;
			end
		end

		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### window_min_sum_2d_unit.f
rtl/core/wmsum_pkg.sv
rtl/core/wmsum_ctrl.sv
rtl/core/wmsum_dpath.sv
rtl/core/window_min_sum_2d_unit.sv
tb/window_min_sum_2d_unit_test.sv
